FILE: rtl/core/c2sa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartesian to spherical angles: shared package
// Widths, angle constants, the arctangent step table and the cell payload
// types used by the CORDIC cell chains.
// ----------------------------------------------------------------------------
package c2sa_pkg;

   // Coordinate and pipeline sizing
   localparam int COORD_WIDTH   = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int NUM_CELLS     = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
   localparam int SHIFT_W       = 5;

   // Coordinates carry 16 fraction bits plus headroom for two CORDIC gains
   localparam int GUARD_SHIFT   = 16;
   localparam int DATA_W        = COORD_WIDTH + GUARD_SHIFT + 4;

   // Internal angles in 1/32768 degree; outputs in 1/128 degree
   localparam int ANG_W         = 26;
   localparam int RND_SHIFT     = 8;
   localparam int RND_W         = ANG_W - RND_SHIFT;
   localparam int AZ_W          = 16;
   localparam int ZE_W          = 15;

   localparam logic signed [ANG_W-1:0] ANG_HALF   = 26'sd5898240;
   localparam logic signed [ANG_W-1:0] ROUND_BIAS = 26'sd128;
   localparam logic signed [RND_W-1:0] OUT_HALF   = 18'sd23040;
   localparam logic signed [RND_W-1:0] OUT_FULL   = 18'sd46080;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
   } vec_type;

   // Payload handed from cell to cell
   typedef struct packed {
      vec_type                  va;    // vector whose angle is accumulated
      vec_type                  vb;    // length-only vector (|z| scaling)
      logic signed [ANG_W-1:0]  ang;   // accumulated angle of va
      logic signed [AZ_W-1:0]   azim;  // finished azimuth, carried along
      logic                     zero;  // all-zero input
      logic                     axis;  // x = y = 0
      logic                     zneg;  // z < 0
   } cell_data_type;

   // atan(2^-i) in 1/32768 degree, rounded to nearest
   function automatic logic signed [ANG_W-1:0] atan_step(input logic [SHIFT_W-1:0] idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         5'd0:    v = 26'sd1474560;
         5'd1:    v = 26'sd870484;
         5'd2:    v = 26'sd459940;
         5'd3:    v = 26'sd233473;
         5'd4:    v = 26'sd117189;
         5'd5:    v = 26'sd58652;
         5'd6:    v = 26'sd29333;
         5'd7:    v = 26'sd14667;
         5'd8:    v = 26'sd7334;
         5'd9:    v = 26'sd3667;
         5'd10:   v = 26'sd1833;
         5'd11:   v = 26'sd917;
         5'd12:   v = 26'sd458;
         5'd13:   v = 26'sd229;
         5'd14:   v = 26'sd115;
         5'd15:   v = 26'sd57;
         5'd16:   v = 26'sd29;
         5'd17:   v = 26'sd14;
         5'd18:   v = 26'sd7;
         5'd19:   v = 26'sd4;
         5'd20:   v = 26'sd2;
         5'd21:   v = 26'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Round internal angle to 1/128 degree: floor((a + 128) / 256)
   function automatic logic signed [RND_W-1:0] round_ang(input logic signed [ANG_W-1:0] a);
      logic signed [ANG_W-1:0] t;
      t = a + ROUND_BIAS;
      return $signed(t[ANG_W-1:RND_SHIFT]);
   endfunction

endpackage

FILE: rtl/core/c2sa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC vectoring cell
// One registered micro-rotation on two vectors at a fixed shift, with its
// own valid bit and a ready that lets bubbles close up in the chain.
// ----------------------------------------------------------------------------
module c2sa_cell (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [c2sa_pkg::SHIFT_W-1:0]           shift,
   input  logic signed [c2sa_pkg::ANG_W-1:0]      step,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  c2sa_pkg::cell_data_type                in_data,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output c2sa_pkg::cell_data_type                out_data
);
   import c2sa_pkg::*;

   logic                     valid_ff;
   cell_data_type            data_ff;
   cell_data_type            data_in;
   logic signed [DATA_W-1:0] ax, ay, bx, by;
   logic signed [DATA_W-1:0] ax_sh, ay_sh, bx_sh, by_sh;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // micro-rotation: drive y toward zero
   always_comb begin
      ax    = in_data.va.x;
      ay    = in_data.va.y;
      bx    = in_data.vb.x;
      by    = in_data.vb.y;
      ax_sh = ax >>> shift;
      ay_sh = ay >>> shift;
      bx_sh = bx >>> shift;
      by_sh = by >>> shift;
      data_in = in_data;
      if (!ay[DATA_W-1]) begin
         data_in.va.x = ax + ay_sh;
         data_in.va.y = ay - ax_sh;
         data_in.ang  = in_data.ang + step;
      end else begin
         data_in.va.x = ax - ay_sh;
         data_in.va.y = ay + ax_sh;
         data_in.ang  = in_data.ang - step;
      end
      if (!by[DATA_W-1]) begin
         data_in.vb.x = bx + by_sh;
         data_in.vb.y = by - bx_sh;
      end else begin
         data_in.vb.x = bx - by_sh;
         data_in.vb.y = by + bx_sh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: rtl/core/c2sa_join.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartesian to spherical angles: join stage
// Finishes the azimuth and sets up the zenith pass on (gain*z, r), folding
// a negative z into the right half plane.
// ----------------------------------------------------------------------------
module c2sa_join (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  c2sa_pkg::cell_data_type    in_data,
   output logic                       out_valid,
   input  logic                       out_ready,
   output c2sa_pkg::cell_data_type    out_data
);
   import c2sa_pkg::*;

   logic                     valid_ff;
   cell_data_type            data_ff;
   cell_data_type            data_in;
   logic signed [RND_W-1:0]  az;
   logic signed [DATA_W-1:0] zk, r;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      // azimuth: round, force 0 on the z axis, wrap into (-180, 180]
      az = round_ang(in_data.ang);
      if (in_data.axis) begin
         az = '0;
      end
      if (az <= -OUT_HALF) begin
         az = az + OUT_FULL;
      end else if (az > OUT_HALF) begin
         az = az - OUT_FULL;
      end

      // zenith pass inputs
      zk = in_data.zneg ? -in_data.vb.x : in_data.vb.x;
      r  = in_data.va.x;

      data_in      = '0;
      data_in.azim = az[AZ_W-1:0];
      data_in.zero = in_data.zero;
      data_in.axis = in_data.axis;
      if (zk[DATA_W-1]) begin
         data_in.va.x = -zk;
         data_in.va.y = -r;
         data_in.ang  = r[DATA_W-1] ? -ANG_HALF : ANG_HALF;
      end else begin
         data_in.va.x = zk;
         data_in.va.y = r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: rtl/core/cartesian_to_spherical_angles.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartesian to spherical angles
// Pipelined CORDIC that turns a target vector (x, y, z) into azimuth and
// zenith angles in 1/128 degree.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one target vector per item; rsp_* returns one result item
//   per request, in order: azimuth atan2(y, x) in (-180, 180], zenith from
//   +z in [0, 180], and zero_vector for the all-zero input (angles 0).
//   Both channels are valid/ready.
//   Throughput: one item per cycle while rsp_ready stays high. Each item
//   passes through the two chains of CORDIC cells (azimuth and |z|
//   scaling in parallel, then the zenith chain), the join stage and the
//   output register.
//   Every stage has its own valid bit, so when the receiver stalls the
//   chain keeps filling its empty stages and req_ready drops only once
//   every stage holds an item. Items are never dropped.
//   Reset (synchronous, active high) empties all stages; no other state.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_angles (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [c2sa_pkg::COORD_WIDTH-1:0]  req_target_x,
   input  logic signed [c2sa_pkg::COORD_WIDTH-1:0]  req_target_y,
   input  logic signed [c2sa_pkg::COORD_WIDTH-1:0]  req_target_z,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [c2sa_pkg::AZ_W-1:0]         rsp_azimuth_angle,
   output logic [c2sa_pkg::ZE_W-1:0]                rsp_zenith_angle,
   output logic                                     rsp_zero_vector
);
   import c2sa_pkg::*;

   localparam int PAD_W = DATA_W - COORD_WIDTH - GUARD_SHIFT;

   cell_data_type            c1_data  [NUM_CELLS+1];
   logic                     c1_valid [NUM_CELLS+1];
   logic                     c1_ready [NUM_CELLS+1];
   cell_data_type            c2_data  [NUM_CELLS+1];
   logic                     c2_valid [NUM_CELLS+1];
   logic                     c2_ready [NUM_CELLS+1];

   logic signed [DATA_W-1:0] xs, ys, zs;
   cell_data_type            head;
   logic signed [RND_W-1:0]  ze;
   logic [ZE_W-1:0]          ze_clamp;

   logic                     rsp_valid_ff;
   logic signed [AZ_W-1:0]   az_ff;
   logic [ZE_W-1:0]          ze_ff;
   logic                     zero_ff;
   logic                     out_ready;

   // scale coordinates and fold x < 0 into the right half plane
   always_comb begin
      xs = {{PAD_W{req_target_x[COORD_WIDTH-1]}}, req_target_x, {GUARD_SHIFT{1'b0}}};
      ys = {{PAD_W{req_target_y[COORD_WIDTH-1]}}, req_target_y, {GUARD_SHIFT{1'b0}}};
      zs = {{PAD_W{req_target_z[COORD_WIDTH-1]}}, req_target_z, {GUARD_SHIFT{1'b0}}};
      head      = '0;
      head.axis = (req_target_x == '0) && (req_target_y == '0);
      head.zero = head.axis && (req_target_z == '0);
      head.zneg = zs[DATA_W-1];
      if (xs[DATA_W-1]) begin
         head.va.x = -xs;
         head.va.y = -ys;
         head.ang  = ys[DATA_W-1] ? -ANG_HALF : ANG_HALF;
      end else begin
         head.va.x = xs;
         head.va.y = ys;
      end
      head.vb.x = zs[DATA_W-1] ? -zs : zs;
   end

   assign c1_data[0]  = head;
   assign c1_valid[0] = req_valid;
   assign req_ready   = c1_ready[0];

   // first chain: azimuth on (x, y) and gain scaling of |z|
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_chain1
      c2sa_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (SHIFT_W'(i)),
         .step      (atan_step(SHIFT_W'(i))),
         .in_valid  (c1_valid[i]),
         .in_ready  (c1_ready[i]),
         .in_data   (c1_data[i]),
         .out_valid (c1_valid[i+1]),
         .out_ready (c1_ready[i+1]),
         .out_data  (c1_data[i+1])
      );
   end

   c2sa_join u_join (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c1_valid[NUM_CELLS]),
      .in_ready  (c1_ready[NUM_CELLS]),
      .in_data   (c1_data[NUM_CELLS]),
      .out_valid (c2_valid[0]),
      .out_ready (c2_ready[0]),
      .out_data  (c2_data[0])
   );

   // second chain: zenith on (gain*z, r)
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_chain2
      c2sa_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (SHIFT_W'(i)),
         .step      (atan_step(SHIFT_W'(i))),
         .in_valid  (c2_valid[i]),
         .in_ready  (c2_ready[i]),
         .in_data   (c2_data[i]),
         .out_valid (c2_valid[i+1]),
         .out_ready (c2_ready[i+1]),
         .out_data  (c2_data[i+1])
      );
   end

   // zenith rounding and clamp to [0, 180]
   always_comb begin
      ze = round_ang(c2_data[NUM_CELLS].ang);
      if (ze[RND_W-1]) begin
         ze_clamp = '0;
      end else if (ze > OUT_HALF) begin
         ze_clamp = OUT_HALF[ZE_W-1:0];
      end else begin
         ze_clamp = ze[ZE_W-1:0];
      end
   end

   // output register
   assign out_ready           = !rsp_valid_ff || rsp_ready;
   assign c2_ready[NUM_CELLS] = out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= c2_valid[NUM_CELLS];
      end
      if (out_ready && c2_valid[NUM_CELLS]) begin
         zero_ff <= c2_data[NUM_CELLS].zero;
         az_ff   <= c2_data[NUM_CELLS].zero ? '0 : c2_data[NUM_CELLS].azim;
         ze_ff   <= c2_data[NUM_CELLS].zero ? '0 : ze_clamp;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_azimuth_angle = az_ff;
   assign rsp_zenith_angle  = ze_ff;
   assign rsp_zero_vector   = zero_ff;

endmodule

FILE: tb/angle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartesian to spherical angles: result checker
// Watches both channels of the angle unit, predicts azimuth, zenith and the
// zero flag for every accepted target vector, and compares each returned
// item field by field against the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module angle_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_ready,
   input  logic signed [c2sa_pkg::COORD_WIDTH-1:0]  req_target_x,
   input  logic signed [c2sa_pkg::COORD_WIDTH-1:0]  req_target_y,
   input  logic signed [c2sa_pkg::COORD_WIDTH-1:0]  req_target_z,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   input  logic signed [c2sa_pkg::AZ_W-1:0]         rsp_azimuth_angle,
   input  logic [c2sa_pkg::ZE_W-1:0]                rsp_zenith_angle,
   input  logic                                     rsp_zero_vector,
   output int                                       fail_count,
   output int                                       pending,
   output int                                       checked,
   output int                                       zero_seen,
   output int                                       input_stalls
);

   // Same stage cap as the hardware: more than 32 stages act as 32
   localparam int     PASSES        = (c2sa_pkg::CORDIC_STAGES > 32) ? 32 :
                                      c2sa_pkg::CORDIC_STAGES;
   localparam longint HALF_TURN     = 64'sd5898240;   // 180 deg in 1/32768 deg
   localparam longint OUT_HALF_TURN = 64'sd23040;     // 180 deg in 1/128 deg
   localparam longint OUT_TURN      = 64'sd46080;
   localparam int     REPORT_CAP    = 40;

   typedef struct packed {
      logic signed [c2sa_pkg::AZ_W-1:0] azimuth;
      logic [c2sa_pkg::ZE_W-1:0]        zenith;
      logic                             zero;
   } angles_type;

   typedef struct {
      logic signed [c2sa_pkg::COORD_WIDTH-1:0] tx;
      logic signed [c2sa_pkg::COORD_WIDTH-1:0] ty;
      logic signed [c2sa_pkg::COORD_WIDTH-1:0] tz;
      angles_type                              want;
   } due_item_type;

   // atan(2^-i) in 1/32768 degree
   longint atan_lut [0:31] = '{
      1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
      7334, 3667, 1833, 917, 458, 229, 115, 57,
      29, 14, 7, 4, 2, 1, 0, 0,
      0, 0, 0, 0, 0, 0, 0, 0
   };

   due_item_type angles_due [$];
   int           errs;
   int           n_checked;
   int           n_zero;
   int           n_stalls;

   // Vectoring rotation toward +x (px >= 0); returns the swept angle
   function automatic longint rotate_to_axis(input longint px, input longint py,
                                             output longint len);
      longint acc;
      longint dx;
      longint dy;
      acc = 0;
      for (int i = 0; i < PASSES; i++) begin
         dx = py >>> i;
         dy = px >>> i;
         if (py >= 0) begin
            px  = px + dx;
            py  = py - dy;
            acc = acc + atan_lut[i];
         end else begin
            px  = px - dx;
            py  = py + dy;
            acc = acc - atan_lut[i];
         end
      end
      len = px;
      return acc;
   endfunction

   // Four-quadrant angle: fold the left half plane over first
   function automatic longint angle_of(input longint py, input longint px,
                                       output longint len);
      longint base;
      base = 0;
      if (px < 0) begin
         base = (py >= 0) ? HALF_TURN : -HALF_TURN;
         px   = -px;
         py   = -py;
      end
      return base + rotate_to_axis(px, py, len);
   endfunction

   function automatic longint to_out_units(input longint a);
      return (a + 128) >>> 8;
   endfunction

   function automatic angles_type predict_angles(
         input logic signed [c2sa_pkg::COORD_WIDTH-1:0] tx,
         input logic signed [c2sa_pkg::COORD_WIDTH-1:0] ty,
         input logic signed [c2sa_pkg::COORD_WIDTH-1:0] tz);
      angles_type res;
      longint     xs;
      longint     ys;
      longint     zs;
      longint     plane;
      longint     zlen;
      longint     spare;
      longint     az;
      longint     ze;
      res = '0;
      if (tx == 0 && ty == 0 && tz == 0) begin
         res.zero = 1'b1;
         return res;
      end
      xs = longint'(tx) * 65536;
      ys = longint'(ty) * 65536;
      zs = longint'(tz) * 65536;

      // azimuth; forced to 0 on the z axis, then wrapped into (-180, 180]
      az = to_out_units(angle_of(ys, xs, plane));
      if (tx == 0 && ty == 0) begin
         az    = 0;
         plane = 0;
      end
      if (az <= -OUT_HALF_TURN) az = az + OUT_TURN;
      if (az > OUT_HALF_TURN)   az = az - OUT_TURN;

      // |z| through the same gain so it matches the planar length
      void'(rotate_to_axis((zs < 0) ? -zs : zs, 0, zlen));
      if (zs < 0) zlen = -zlen;
      ze = to_out_units(angle_of(plane, zlen, spare));
      if (ze < 0)             ze = 0;
      if (ze > OUT_HALF_TURN) ze = OUT_HALF_TURN;

      res.azimuth = az[c2sa_pkg::AZ_W-1:0];
      res.zenith  = ze[c2sa_pkg::ZE_W-1:0];
      return res;
   endfunction

   function automatic void report(input string what, input longint want, input longint got);
      errs = errs + 1;
      if (errs <= REPORT_CAP)
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      else if (errs == REPORT_CAP + 1)
         $display("%0t: further mismatch reports suppressed", $time);
   endfunction

   initial begin
      errs      = 0;
      n_checked = 0;
      n_zero    = 0;
      n_stalls  = 0;
   end

   // Predict on input acceptance, compare on result acceptance
   always @(posedge clock) begin
      due_item_type due;
      if (reset) begin
         angles_due.delete();
      end else begin
         if (req_valid && !req_ready)
            n_stalls = n_stalls + 1;
         if (req_valid && req_ready) begin
            due.tx   = req_target_x;
            due.ty   = req_target_y;
            due.tz   = req_target_z;
            due.want = predict_angles(req_target_x, req_target_y, req_target_z);
            angles_due.push_back(due);
         end
         if (rsp_valid && rsp_ready) begin
            if (angles_due.size() == 0) begin
               errs = errs + 1;
               $display("%0t: result item with nothing outstanding, az %0d ze %0d zero %0d",
                        $time, rsp_azimuth_angle, rsp_zenith_angle, rsp_zero_vector);
            end else begin
               due = angles_due.pop_front();
               n_checked = n_checked + 1;
               if (rsp_zero_vector === 1'b1)
                  n_zero = n_zero + 1;
               if (rsp_azimuth_angle !== due.want.azimuth || rsp_zenith_angle !==
                   due.want.zenith || rsp_zero_vector !== due.want.zero)
                  $display("%0t: vector (%0d, %0d, %0d)", $time, due.tx, due.ty, due.tz);
               if (rsp_azimuth_angle !== due.want.azimuth)
                  report("azimuth", due.want.azimuth, rsp_azimuth_angle);
               if (rsp_zenith_angle !== due.want.zenith)
                  report("zenith", due.want.zenith, rsp_zenith_angle);
               if (rsp_zero_vector !== due.want.zero)
                  report("zero flag", due.want.zero, rsp_zero_vector);
            end
         end
      end
      fail_count   <= errs;
      pending      <= angles_due.size();
      checked      <= n_checked;
      zero_seen    <= n_zero;
      input_stalls <= n_stalls;
   end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartesian to spherical angles: testbench top
// Drives target vectors into the angle unit with random gaps and bursts,
// throttles the result side with random and long stalls, and reports the
// verdict from the checker's failure count and outstanding results.
// ----------------------------------------------------------------------------
module tb;

   localparam int CW             = c2sa_pkg::COORD_WIDTH;
   localparam int ITEMS_RANDOM   = 1575;
   localparam int HOLD_CYCLES    = 250;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 2 * c2sa_pkg::NUM_CELLS + 12;

   typedef enum int {
      MIX_FULL   = 0,
      MIX_SMALL  = 1,
      MIX_AXIS   = 2,
      MIX_BACK   = 3,
      MIX_CORNER = 4,
      MIX_FLAT   = 5
   } mix_kind_type;

   logic                            clock;
   logic                            reset         = 1'b1;
   logic                            req_valid     = 1'b0;
   logic                            req_ready;
   logic signed [CW-1:0]            req_target_x  = '0;
   logic signed [CW-1:0]            req_target_y  = '0;
   logic signed [CW-1:0]            req_target_z  = '0;
   logic                            rsp_valid;
   logic                            rsp_ready     = 1'b0;
   logic signed [c2sa_pkg::AZ_W-1:0] rsp_azimuth_angle;
   logic [c2sa_pkg::ZE_W-1:0]       rsp_zenith_angle;
   logic                            rsp_zero_vector;

   int fail_count;
   int pending;
   int checked;
   int zero_seen;
   int input_stalls;
   int idle_cycles   = 0;
   int sent          = 0;
   bit send_burst    = 1'b0;
   bit rcv_burst     = 1'b0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   cartesian_to_spherical_angles u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_target_x      (req_target_x),
      .req_target_y      (req_target_y),
      .req_target_z      (req_target_z),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_azimuth_angle (rsp_azimuth_angle),
      .rsp_zenith_angle  (rsp_zenith_angle),
      .rsp_zero_vector   (rsp_zero_vector)
   );

   angle_checker u_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_target_x      (req_target_x),
      .req_target_y      (req_target_y),
      .req_target_z      (req_target_z),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_azimuth_angle (rsp_azimuth_angle),
      .rsp_zenith_angle  (rsp_zenith_angle),
      .rsp_zero_vector   (rsp_zero_vector),
      .fail_count        (fail_count),
      .pending           (pending),
      .checked           (checked),
      .zero_seen         (zero_seen),
      .input_stalls      (input_stalls)
   );

   // Offer one vector; valid stays up from one item to the next in bursts
   task automatic send_vector(input logic signed [CW-1:0] tx, input logic signed [CW-1:0] ty,
                              input logic signed [CW-1:0] tz);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_target_x <= tx;
      req_target_y <= ty;
      req_target_z <= tz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent = sent + 1;
   endtask

   function automatic logic signed [CW-1:0] corner_value();
      case ($urandom_range(0, 5))
         0:       return CW'(-32768);
         1:       return CW'(-32767);
         2:       return CW'(-1);
         3:       return CW'(0);
         4:       return CW'(1);
         default: return CW'(32767);
      endcase
   endfunction

   task automatic make_vector(output logic signed [CW-1:0] tx, output logic signed [CW-1:0] ty,
                              output logic signed [CW-1:0] tz);
      int           r;
      mix_kind_type kind;
      r    = $urandom_range(0, 9);
      kind = (r < 5) ? MIX_FULL : mix_kind_type'(r - 4);
      tx   = CW'($urandom);
      ty   = CW'($urandom);
      tz   = CW'($urandom);
      case (kind)
         // tiny coordinates hit the axes and the zero vector often
         MIX_SMALL: begin
            tx = CW'(int'($urandom_range(0, 16)) - 8);
            ty = CW'(int'($urandom_range(0, 16)) - 8);
            tz = CW'(int'($urandom_range(0, 16)) - 8);
         end
         MIX_AXIS: begin
            tx = '0;
            ty = '0;
         end
         // negative x with y near zero: azimuth close to +-180
         MIX_BACK: begin
            tx = CW'(-int'($urandom_range(1, 32768)));
            ty = CW'(int'($urandom_range(0, 2)) - 1);
         end
         MIX_CORNER: begin
            tx = corner_value();
            ty = corner_value();
            tz = corner_value();
         end
         MIX_FLAT: begin
            case ($urandom_range(0, 2))
               0:       tx = '0;
               1:       ty = '0;
               default: tz = '0;
            endcase
         end
         default: ;
      endcase
   endtask

   // Result side: random stalls, bursts, and two long hold-offs
   initial begin
      int stall;
      int got;
      got = 0;
      while (reset) @(posedge clock);
      forever begin
         if (got % 50 == 0)
            rcv_burst = ($urandom_range(0, 2) == 0);
         stall = rcv_burst ? 0 : $urandom_range(0, 5);
         if (got == 300 || got == 1000)
            stall = HOLD_CYCLES;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got = got + 1;
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      logic signed [CW-1:0] vx;
      logic signed [CW-1:0] vy;
      logic signed [CW-1:0] vz;
      int                   directed;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // corners, axes and the wrap near -180
      send_vector(0, 0, 0);
      send_vector(0, 0, 1);
      send_vector(0, 0, -1);
      send_vector(0, 0, 32767);
      send_vector(0, 0, -32768);
      send_vector(1, 0, 0);
      send_vector(32767, 0, 0);
      send_vector(-32768, 0, 0);
      send_vector(-7, 0, 0);
      send_vector(0, 32767, 0);
      send_vector(0, -32768, 0);
      send_vector(-32768, -1, 0);
      send_vector(-32768, 1, 0);
      send_vector(-1, 0, 5);
      send_vector(32767, 32767, 32767);
      send_vector(-32768, -32768, -32768);
      send_vector(1, 1, 1);
      send_vector(-1, -1, -1);
      send_vector(32767, -32768, 0);
      send_vector(-32768, 32767, -32768);
      send_vector(5, 0, -3);
      send_vector(0, 1, 32767);
      send_vector(-1, 0, -32768);
      send_vector(12345, -23456, 3210);
      send_vector(-21, 17, 0);
      directed = sent;

      for (int n = 0; n < ITEMS_RANDOM; n++) begin
         if (n % 50 == 0)
            send_burst = ($urandom_range(0, 2) == 0);
         make_vector(vx, vy, vz);
         send_vector(vx, vy, vz);
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d target vectors (%0d directed): %0d results checked, %0d zero vectors.",
               sent, directed, checked, zero_seen);
      $display("Input was held off for %0d cycles while the result side stalled.",
               input_stalls);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d failures, %0d results outstanding", fail_count, pending);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
